// ===== hdl/lmi_pkg.sv =====
`timescale 1ns / 1ps
package lmi_pkg;

  // field widths
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 6;
  localparam int RAD_W    = 23;
  localparam int VEL_W    = 20;
  localparam int RAY_W    = 32;
  localparam int BOUND_W  = 8;
  localparam int COUNT_W  = 7;
  localparam int SEG_W    = 6;

  localparam int DEFAULT_MAX_LAYERS = 64;
  localparam int LAYER_COUNT_RESET  = 2;

  // divider widths
  localparam int NUM_W = 78;
  localparam int DEN_W = 54;
  localparam int QUO_W = 24;

  localparam logic [VEL_W-1:0] VEL_MAX = {VEL_W{1'b1}};
  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_VEL  = 2'd1,
    OP_TURN = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH,
    ST_PROBE,
    ST_PCMP,
    ST_SEG,
    ST_RD0,
    ST_RD1,
    ST_VMUL,
    ST_VSET,
    ST_VPOST,
    ST_TM1,
    ST_TM2,
    ST_TM3,
    ST_TM4,
    ST_TM5,
    ST_TM6,
    ST_TM7,
    ST_DIV,
    ST_TPOST,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ===== hdl/lmi_if.sv =====
`timescale 1ns / 1ps
interface lmi_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [lmi_pkg::OPCODE_W-1:0]          opcode;
  logic                                  wave_select;
  logic [lmi_pkg::INDEX_W-1:0]           layer_index;
  logic [lmi_pkg::RAD_W-1:0]             layer_radius;
  logic [lmi_pkg::VEL_W-1:0]             layer_p_velocity;
  logic [lmi_pkg::VEL_W-1:0]             layer_s_velocity;
  logic [lmi_pkg::RAD_W-1:0]             query_radius;
  logic [lmi_pkg::RAY_W-1:0]             ray_parameter;
  logic signed [lmi_pkg::BOUND_W-1:0]    search_lower;
  logic signed [lmi_pkg::BOUND_W-1:0]    search_upper;

  modport source (output valid, opcode, wave_select, layer_index, layer_radius,
                  layer_p_velocity, layer_s_velocity, query_radius, ray_parameter,
                  search_lower, search_upper, input ready);
  modport sink (input valid, opcode, wave_select, layer_index, layer_radius,
                layer_p_velocity, layer_s_velocity, query_radius, ray_parameter,
                search_lower, search_upper, output ready);
endinterface

interface lmi_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [lmi_pkg::VEL_W-1:0]     p_velocity;
  logic [lmi_pkg::VEL_W-1:0]     s_velocity;
  logic [lmi_pkg::RAD_W-1:0]     turn_radius;
  logic [lmi_pkg::SEG_W-1:0]     segment_index;
  logic                          degenerate;
  logic                          saturated;

  modport source (output valid, result_kind, p_velocity, s_velocity, turn_radius,
                  segment_index, degenerate, saturated, input ready);
  modport sink (input valid, result_kind, p_velocity, s_velocity, turn_radius,
                segment_index, degenerate, saturated, output ready);
endinterface

interface lmi_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lmi_pkg::COUNT_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/layered_model_interpolator_top.sv =====
`timescale 1ns / 1ps
// layered model interpolator
// in_chan carries load, velocity query and turn radius query items; a load
// writes one table entry and gives no result, each query gives one item on
// out_chan. cfg_chan writes the layer count (always ready); write it only
// while the block is idle.
// one item at a time: in_chan.ready is high only between items. a query
// binary-searches the table with one table read per probe (a turn probe adds
// a multiply), reads the two segment entries, then runs the shared 33x25
// multiplier and a 24-step restoring divider, twice for a velocity query.
// the result sits in an output register; a stalled receiver holds it there,
// and the block takes the next item meanwhile, waiting only to hand over the
// following result. reset clears the control state and sets the layer count
// to 2; table contents are undefined until loaded.
module layered_model_interpolator_top #(
  parameter int MAX_LAYERS = lmi_pkg::DEFAULT_MAX_LAYERS
) (
  input logic       clk,
  input logic       rst_n,
  lmi_in_if.sink    in_chan,
  lmi_out_if.source out_chan,
  lmi_cfg_if.sink   cfg_chan
);
  localparam int AW  = $clog2(MAX_LAYERS);
  localparam int IW  = ((AW + 1 > lmi_pkg::BOUND_W) ? AW + 1 : lmi_pkg::BOUND_W) + 2;
  localparam int RW  = lmi_pkg::RAD_W;
  localparam int VW  = lmi_pkg::VEL_W;
  localparam int WW  = 2 * lmi_pkg::VEL_W;
  localparam int NW  = lmi_pkg::NUM_W;
  localparam int DW  = lmi_pkg::DEN_W;
  localparam int QW  = lmi_pkg::QUO_W;
  localparam int MW  = 58;
  localparam int PW  = 55;

  lmi_pkg::st_t state_r, state_nxt;

  // table memory: {velocity word, radius}
  logic [WW+RW-1:0] mem [MAX_LAYERS];
  logic [WW+RW-1:0] rd_q_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  logic [lmi_pkg::COUNT_W-1:0] layer_count_r;

  logic [1:0]             op_r, op_nxt;
  logic                   col_r, col_nxt;
  logic [RW-1:0]          qrad_r, qrad_nxt;
  logic [lmi_pkg::RAY_W-1:0] ray_r, ray_nxt;
  logic signed [IW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [AW-1:0]          seg_r, seg_nxt;
  logic [RW-1:0]          r0_r, r0_nxt, r1_r, r1_nxt, prad_r, prad_nxt;
  logic [WW-1:0]          w0_r, w0_nxt, w1_r, w1_nxt;
  logic                   pvz_r, pvz_nxt;
  logic signed [MW-1:0]   mul_r, den_r, den_nxt, k_r, k_nxt;
  logic [PW-1:0]          nlo_r, nlo_nxt;
  logic                   neg_r, neg_nxt;
  logic [VW-1:0]          res_p_r, res_p_nxt, res_s_r, res_s_nxt;
  logic [RW-1:0]          res_t_r, res_t_nxt;
  logic                   deg_r, deg_nxt, sat_r, sat_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   o_kind_r;
  logic [VW-1:0]          o_p_r, o_s_r;
  logic [RW-1:0]          o_t_r;
  logic [lmi_pkg::SEG_W-1:0] o_seg_r;
  logic                   o_deg_r, o_sat_r;
  logic                   out_load;

  logic signed [32:0]     mul_a;
  logic signed [24:0]     mul_b;

  logic                   div_start;
  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  lmi_pkg::div_stat_t     div_stat;
  logic [QW-1:0]          div_quo;

  logic                   in_acc;
  logic signed [IW-1:0]   n_s, lc_s;
  logic signed [IW:0]     sum_s, diff_s;
  logic signed [IW-1:0]   mid_s, addr_s, seg_s;
  logic                   more;
  logic [VW-1:0]          v0c, v1c, pvv;
  logic signed [VW:0]     dv;
  logic signed [RW:0]     dr, dq;
  logic signed [MW-1:0]   dr_sh;
  logic [45:0]            km, numag;
  logic [DW-1:0]          den_mag;
  logic signed [26:0]     vsum;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == lmi_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  // used layer count, clamped to [2, MAX_LAYERS]
  always_comb begin
    lc_s = IW'({1'b0, layer_count_r});
    if (lc_s < IW'(2)) n_s = IW'(2);
    else if (lc_s > IW'(MAX_LAYERS)) n_s = IW'(MAX_LAYERS);
    else n_s = lc_s;
  end

  // search midpoint, probe address and clamped segment
  always_comb begin
    sum_s  = {hi_r[IW-1], hi_r} + {lo_r[IW-1], lo_r};
    diff_s = {hi_r[IW-1], hi_r} - {lo_r[IW-1], lo_r};
    mid_s  = sum_s[IW:1];
    more   = (diff_s > (IW+1)'(1));
    if (mid_s < 0) addr_s = '0;
    else if (mid_s > n_s - 1'b1) addr_s = n_s - 1'b1;
    else addr_s = mid_s;
    if (lo_r < 0) seg_s = '0;
    else if (lo_r > n_s - IW'(2)) seg_s = n_s - IW'(2);
    else seg_s = lo_r;
  end

  // segment differences for the selected column
  always_comb begin
    v0c     = col_r ? w0_r[WW-1:VW] : w0_r[VW-1:0];
    v1c     = col_r ? w1_r[WW-1:VW] : w1_r[VW-1:0];
    pvv     = col_r ? rd_q_r[WW+RW-1:VW+RW] : rd_q_r[VW+RW-1:RW];
    dv      = $signed({1'b0, v1c}) - $signed({1'b0, v0c});
    dr      = $signed({1'b0, r1_r}) - $signed({1'b0, r0_r});
    dq      = $signed({1'b0, qrad_r}) - $signed({1'b0, r0_r});
    dr_sh   = MW'(dr) <<< 16;
    km      = k_r[MW-1] ? 46'(-k_r) : 46'(k_r);
    numag   = mul_r[MW-1] ? 46'(-mul_r) : 46'(mul_r);
    den_mag = den_r[MW-1] ? DW'(-den_r) : DW'(den_r);
    vsum    = neg_r ? ($signed({7'b0, v0c}) - $signed({3'b0, div_quo}))
                    : ($signed({7'b0, v0c}) + $signed({3'b0, div_quo}));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lmi_pkg::ST_IDLE: begin
        if (in_acc && (in_chan.opcode == lmi_pkg::OP_VEL || in_chan.opcode == lmi_pkg::OP_TURN))
          state_nxt = lmi_pkg::ST_SRCH;
      end
      lmi_pkg::ST_SRCH: state_nxt = more ? lmi_pkg::ST_PROBE : lmi_pkg::ST_SEG;
      lmi_pkg::ST_PROBE: begin
        state_nxt = (op_r == lmi_pkg::OP_VEL) ? lmi_pkg::ST_SRCH : lmi_pkg::ST_PCMP;
      end
      lmi_pkg::ST_PCMP: state_nxt = lmi_pkg::ST_SRCH;
      lmi_pkg::ST_SEG:  state_nxt = lmi_pkg::ST_RD0;
      lmi_pkg::ST_RD0:  state_nxt = lmi_pkg::ST_RD1;
      lmi_pkg::ST_RD1: begin
        state_nxt = (op_r == lmi_pkg::OP_VEL) ? lmi_pkg::ST_VMUL : lmi_pkg::ST_TM1;
      end
      lmi_pkg::ST_VMUL: state_nxt = (dr == 0) ? lmi_pkg::ST_DONE : lmi_pkg::ST_VSET;
      lmi_pkg::ST_VSET: state_nxt = lmi_pkg::ST_DIV;
      lmi_pkg::ST_VPOST: state_nxt = col_r ? lmi_pkg::ST_DONE : lmi_pkg::ST_VMUL;
      lmi_pkg::ST_TM1: state_nxt = lmi_pkg::ST_TM2;
      lmi_pkg::ST_TM2: state_nxt = lmi_pkg::ST_TM3;
      lmi_pkg::ST_TM3: state_nxt = lmi_pkg::ST_TM4;
      lmi_pkg::ST_TM4: state_nxt = lmi_pkg::ST_TM5;
      lmi_pkg::ST_TM5: state_nxt = (den_r == 0) ? lmi_pkg::ST_DONE : lmi_pkg::ST_TM6;
      lmi_pkg::ST_TM6: state_nxt = lmi_pkg::ST_TM7;
      lmi_pkg::ST_TM7: state_nxt = lmi_pkg::ST_DIV;
      lmi_pkg::ST_DIV: begin
        if (div_stat.done)
          state_nxt = (op_r == lmi_pkg::OP_VEL) ? lmi_pkg::ST_VPOST : lmi_pkg::ST_TPOST;
      end
      lmi_pkg::ST_TPOST: state_nxt = lmi_pkg::ST_DONE;
      lmi_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) state_nxt = lmi_pkg::ST_IDLE;
      end
      default: state_nxt = lmi_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    op_nxt = op_r; col_nxt = col_r; qrad_nxt = qrad_r; ray_nxt = ray_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r; seg_nxt = seg_r;
    r0_nxt = r0_r; r1_nxt = r1_r; w0_nxt = w0_r; w1_nxt = w1_r;
    prad_nxt = prad_r; pvz_nxt = pvz_r; den_nxt = den_r; k_nxt = k_r;
    nlo_nxt = nlo_r; neg_nxt = neg_r;
    res_p_nxt = res_p_r; res_s_nxt = res_s_r; res_t_nxt = res_t_r;
    deg_nxt = deg_r; sat_nxt = sat_r;
    mul_a = '0; mul_b = '0;
    rd_addr = '0; wr_en = 1'b0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    out_load = 1'b0;
    case (state_r)
      lmi_pkg::ST_IDLE: begin
        op_nxt   = in_chan.opcode;
        col_nxt  = (in_chan.opcode == lmi_pkg::OP_TURN) ? in_chan.wave_select : 1'b0;
        qrad_nxt = in_chan.query_radius;
        ray_nxt  = in_chan.ray_parameter;
        if (in_chan.opcode == lmi_pkg::OP_TURN) begin
          lo_nxt = IW'(in_chan.search_lower);
          hi_nxt = IW'(in_chan.search_upper);
        end else begin
          lo_nxt = -IW'(1);
          hi_nxt = n_s;
        end
        res_p_nxt = '0; res_s_nxt = '0; res_t_nxt = '0;
        deg_nxt = 1'b0; sat_nxt = 1'b0;
        wr_en = in_acc && (in_chan.opcode == lmi_pkg::OP_LOAD)
                && (32'(in_chan.layer_index) < 32'(MAX_LAYERS));
      end
      lmi_pkg::ST_SRCH: begin
        mid_nxt = mid_s;
        rd_addr = AW'(addr_s);
      end
      lmi_pkg::ST_PROBE: begin
        if (op_r == lmi_pkg::OP_VEL) begin
          if (qrad_r > rd_q_r[RW-1:0]) lo_nxt = mid_r;
          else hi_nxt = mid_r;
        end
        prad_nxt = rd_q_r[RW-1:0];
        pvz_nxt  = (pvv == '0);
        mul_a    = $signed({1'b0, ray_r});
        mul_b    = $signed({5'b0, pvv});
      end
      lmi_pkg::ST_PCMP: begin
        if (!pvz_r && (mul_r > $signed(MW'({prad_r, 16'b0})))) lo_nxt = mid_r;
        else hi_nxt = mid_r;
      end
      lmi_pkg::ST_SEG: begin
        seg_nxt = AW'(seg_s);
        rd_addr = AW'(seg_s);
      end
      lmi_pkg::ST_RD0: begin
        r0_nxt  = rd_q_r[RW-1:0];
        w0_nxt  = rd_q_r[WW+RW-1:RW];
        rd_addr = seg_r + 1'b1;
      end
      lmi_pkg::ST_RD1: begin
        r1_nxt = rd_q_r[RW-1:0];
        w1_nxt = rd_q_r[WW+RW-1:RW];
      end
      lmi_pkg::ST_VMUL: begin
        if (dr == 0) begin
          deg_nxt   = 1'b1;
          res_p_nxt = w0_r[VW-1:0];
          res_s_nxt = w0_r[WW-1:VW];
        end
        mul_a = 33'(dq);
        mul_b = 25'(dv);
      end
      lmi_pkg::ST_VSET: begin
        neg_nxt   = mul_r[MW-1] ^ dr[RW];
        div_start = 1'b1;
        div_num   = NW'(numag);
        div_den   = DW'(dr[RW] ? -dr : dr);
      end
      lmi_pkg::ST_VPOST: begin
        if (div_stat.ovf) begin
          sat_nxt = 1'b1;
          if (col_r) res_s_nxt = neg_r ? '0 : lmi_pkg::VEL_MAX;
          else res_p_nxt = neg_r ? '0 : lmi_pkg::VEL_MAX;
        end else if (vsum < 0) begin
          sat_nxt = 1'b1;
          if (col_r) res_s_nxt = '0;
          else res_p_nxt = '0;
        end else if (vsum > $signed(27'(lmi_pkg::VEL_MAX))) begin
          sat_nxt = 1'b1;
          if (col_r) res_s_nxt = lmi_pkg::VEL_MAX;
          else res_p_nxt = lmi_pkg::VEL_MAX;
        end else begin
          if (col_r) res_s_nxt = VW'(vsum);
          else res_p_nxt = VW'(vsum);
        end
        col_nxt = 1'b1;
      end
      lmi_pkg::ST_TM1: begin
        mul_a = $signed({1'b0, ray_r});
        mul_b = 25'(dv);
      end
      lmi_pkg::ST_TM2: begin
        den_nxt = mul_r - dr_sh;
        mul_a   = $signed({10'b0, r0_r});
        mul_b   = 25'(dv);
      end
      lmi_pkg::ST_TM3: begin
        k_nxt = mul_r;
        mul_a = $signed({13'b0, v0c});
        mul_b = 25'(dr);
      end
      lmi_pkg::ST_TM4: k_nxt = k_r - mul_r;
      lmi_pkg::ST_TM5: begin
        if (den_r == 0) begin
          deg_nxt   = 1'b1;
          res_t_nxt = r0_r;
        end
        neg_nxt = k_r[MW-1] ^ den_r[MW-1];
        mul_a   = $signed({1'b0, ray_r});
        mul_b   = $signed({2'b0, km[22:0]});
      end
      lmi_pkg::ST_TM6: begin
        nlo_nxt = mul_r[PW-1:0];
        mul_a   = $signed({1'b0, ray_r});
        mul_b   = $signed({2'b0, km[45:23]});
      end
      lmi_pkg::ST_TM7: begin
        div_start = 1'b1;
        div_num   = NW'(nlo_r) + (NW'(mul_r[PW-1:0]) << 23);
        div_den   = den_mag;
      end
      lmi_pkg::ST_TPOST: begin
        if (neg_r) begin
          sat_nxt   = div_stat.ovf || (div_quo != '0);
          res_t_nxt = '0;
        end else if (div_stat.ovf || (div_quo > QW'(lmi_pkg::RAD_MAX))) begin
          sat_nxt   = 1'b1;
          res_t_nxt = lmi_pkg::RAD_MAX;
        end else begin
          res_t_nxt = RW'(div_quo);
        end
      end
      lmi_pkg::ST_DONE: out_load = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  lmi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en)
      mem[AW'(in_chan.layer_index)] <= {in_chan.layer_s_velocity, in_chan.layer_p_velocity,
                                        in_chan.layer_radius};
    rd_q_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lmi_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      layer_count_r <= lmi_pkg::COUNT_W'(lmi_pkg::LAYER_COUNT_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) layer_count_r <= cfg_chan.data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; col_r <= col_nxt; qrad_r <= qrad_nxt; ray_r <= ray_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; mid_r <= mid_nxt; seg_r <= seg_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; w0_r <= w0_nxt; w1_r <= w1_nxt;
    prad_r <= prad_nxt; pvz_r <= pvz_nxt; den_r <= den_nxt; k_r <= k_nxt;
    nlo_r <= nlo_nxt; neg_r <= neg_nxt;
    res_p_r <= res_p_nxt; res_s_r <= res_s_nxt; res_t_r <= res_t_nxt;
    deg_r <= deg_nxt; sat_r <= sat_nxt;
    mul_r <= MW'(mul_a * mul_b);
    if (out_load) begin
      o_kind_r <= (op_r == lmi_pkg::OP_TURN);
      o_p_r    <= res_p_r;
      o_s_r    <= res_s_r;
      o_t_r    <= res_t_r;
      o_seg_r  <= lmi_pkg::SEG_W'(seg_r);
      o_deg_r  <= deg_r;
      o_sat_r  <= sat_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_kind   = o_kind_r;
  assign out_chan.p_velocity    = o_p_r;
  assign out_chan.s_velocity    = o_s_r;
  assign out_chan.turn_radius   = o_t_r;
  assign out_chan.segment_index = o_seg_r;
  assign out_chan.degenerate    = o_deg_r;
  assign out_chan.saturated     = o_sat_r;
endmodule

// ===== hdl/lmi_div.sv =====
`timescale 1ns / 1ps
module lmi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lmi_pkg::NUM_W-1:0]    num,
  input  logic [lmi_pkg::DEN_W-1:0]    den,
  output lmi_pkg::div_stat_t           stat,
  output logic [lmi_pkg::QUO_W-1:0]    quo
);
  localparam int NW = lmi_pkg::NUM_W;
  localparam int DW = lmi_pkg::DEN_W;
  localparam int QW = lmi_pkg::QUO_W;
  localparam int CW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [QW-1:0] low_r, low_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ovf_chk;
  logic [DW:0]   trial;
  logic          ge;

  // quotient of 2^QW or more cannot be formed in QW steps
  assign ovf_chk = (num[NW-1:QW] >= den);
  assign trial   = {rem_r[DW-1:0], low_r[QW-1]};
  assign ge      = (trial >= {1'b0, den_r});

  // one restoring step a cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW);
      den_nxt  = den;
      ovf_nxt  = ovf_chk;
      rem_nxt  = ovf_chk ? '0 : {1'b0, num[NW-1:QW]};
      low_nxt  = num[QW-1:0];
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
        low_nxt = {low_r[QW-2:0], 1'b0};
        quo_nxt = {quo_r[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    ovf_r <= ovf_nxt;
  end

  assign stat.done = busy_r && (cnt_r == '0);
  assign stat.ovf  = ovf_r;
  assign quo       = quo_r;
endmodule
